FILE: src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared beat types and fixed-point constants for the min-max svpwm duty block
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // sqrt(3)/2 and one half in q0.16, one in q1.16 for the duty clamp
  localparam int unsigned SQRT3_HALF_Q16 = 56756;
  localparam int unsigned HALF_Q16       = 32768;
  localparam int unsigned ONE_Q16        = 65536;
  localparam int unsigned DUTY_SHIFT     = 27;
  localparam logic [15:0] PERIOD_RESET   = 16'd3600;

  typedef struct packed {
    logic signed [15:0] alpha_volts;
    logic signed [15:0] beta_volts;
    logic        [15:0] inv_bus;
  } svpwm_in_t;

  typedef struct packed {
    logic [15:0] ticks_a;
    logic [15:0] ticks_b;
    logic [15:0] ticks_c;
    logic        status;
  } svpwm_out_t;

endpackage

FILE: src/svpwm_minmax_duty.sv
// ----------------------------------------------------------------------------
// svpwm_minmax_duty
// space-vector pwm by min-max zero-sequence injection, six-stage pipeline
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  input    | start / busy        | in_data  (alpha, beta, inv_bus)
//  result   | out_strobe          | out_data (ticks_a/b/c, status)
//  config   | cfg_we              | cfg_wdata (pwm period in ticks)
//
//  one beat is taken every clock; busy stays low
//  out_strobe and out_data are registered together at the end of the pipe, so
//  the result is on out_data in the cycle that out_strobe is high
//  the depth is set by the two-part 36x16 duty multiply and the period multiply
//  reset (rst_n low, synchronous) clears the valid chain and loads period 3600
//  results cannot be held off, so nothing in the pipe ever stalls
//
module svpwm_minmax_duty (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  svpwm_pkg::svpwm_in_t   in_data,
  output logic                   out_strobe,
  output svpwm_pkg::svpwm_out_t  out_data,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata
);
  import svpwm_pkg::*;

  // pwm period register
  logic [15:0] period_r;

  // valid chain, one bit per stage
  logic [4:0] vld_r;
  logic       out_strobe_r;

  // stage 1: phase voltages, scaled by 2^16 from the alpha/beta inputs
  logic signed [33:0] s1_ph_r [3];
  logic        [15:0] s1_inv_r;
  logic               s1_nr_r;

  // stage 2: phases plus the min/max common mode
  logic signed [33:0] s2_ph_r [3];
  logic signed [33:0] s2_hi_r;
  logic signed [33:0] s2_lo_r;
  logic        [15:0] s2_inv_r;
  logic               s2_nr_r;

  // stage 3: doubled phase minus the sum of max and min
  logic signed [35:0] s3_d_r [3];
  logic        [15:0] s3_inv_r;
  logic               s3_nr_r;

  // stage 4: partial products of d times inv_bus
  logic signed [33:0] s4_pph_r [3];
  logic        [33:0] s4_ppl_r [3];
  logic               s4_nr_r;

  // stage 5: clamped q1.16 duty
  logic        [16:0] s5_duty_r [3];
  logic               s5_nr_r;

  svpwm_out_t out_data_r;

  // combinational stage values
  logic signed [33:0] c1_ah;
  logic signed [33:0] c1_bm;
  logic signed [33:0] c1_ph [3];
  logic signed [33:0] c2_hi;
  logic signed [33:0] c2_lo;
  logic signed [35:0] c3_d [3];
  logic signed [33:0] c4_pph [3];
  logic        [33:0] c4_ppl [3];
  logic        [16:0] c5_duty [3];
  logic        [15:0] c6_ticks [3];

  assign busy = 1'b0;

  // stage 1: inverse clarke, alpha*1, -alpha/2 +- beta*sqrt3/2
  always_comb begin
    c1_ah = {{3{in_data.alpha_volts[15]}}, in_data.alpha_volts, 15'd0};
    c1_bm = 34'($signed(in_data.beta_volts) * $signed({1'b0, 16'(SQRT3_HALF_Q16)}));
    c1_ph[0] = {{2{in_data.alpha_volts[15]}}, in_data.alpha_volts, 16'd0};
    c1_ph[1] = c1_bm - c1_ah;
    c1_ph[2] = -c1_ah - c1_bm;
  end

  // stage 2: max and min of the three phases
  always_comb begin
    c2_hi = s1_ph_r[0];
    if (s1_ph_r[1] > c2_hi) c2_hi = s1_ph_r[1];
    if (s1_ph_r[2] > c2_hi) c2_hi = s1_ph_r[2];
    c2_lo = s1_ph_r[0];
    if (s1_ph_r[1] < c2_lo) c2_lo = s1_ph_r[1];
    if (s1_ph_r[2] < c2_lo) c2_lo = s1_ph_r[2];
  end

  // stage 3 to 5, per phase
  always_comb begin
    logic signed [51:0] prod;
    logic signed [24:0] quo;
    logic signed [25:0] sum;
    for (int i = 0; i < 3; i++) begin
      // 2x - hi - lo, exact in 36 bits
      c3_d[i] = ({{2{s2_ph_r[i][33]}}, s2_ph_r[i]} <<< 1)
              - {{2{s2_hi_r[33]}}, s2_hi_r} - {{2{s2_lo_r[33]}}, s2_lo_r};
      // split d at bit 18: signed high part, unsigned low part
      c4_pph[i] = 34'($signed(s3_d_r[i][35:18]) * $signed({1'b0, s3_inv_r}));
      c4_ppl[i] = 34'(s3_d_r[i][17:0] * s3_inv_r);
    end
    for (int i = 0; i < 3; i++) begin
      prod = ({{18{s4_pph_r[i][33]}}, s4_pph_r[i]} <<< 18)
           + $signed({18'd0, s4_ppl_r[i]});
      // arithmetic shift gives the floor toward minus infinity
      quo = 25'(prod >>> DUTY_SHIFT);
      sum = {quo[24], quo} + 26'(HALF_Q16);
      if (sum < 0) begin
        c5_duty[i] = '0;
      end else if (sum > 26'(ONE_Q16)) begin
        c5_duty[i] = 17'(ONE_Q16);
      end else begin
        c5_duty[i] = sum[16:0];
      end
    end
  end

  // stage 6: duty times period, keep the integer ticks
  always_comb begin
    logic [32:0] full;
    for (int i = 0; i < 3; i++) begin
      full = 33'(s5_duty_r[i]) * 33'(period_r);
      c6_ticks[i] = full[31:16];
    end
  end

  // control: valid chain and period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
      period_r     <= PERIOD_RESET;
    end else begin
      vld_r        <= {vld_r[3:0], start & ~busy};
      out_strobe_r <= vld_r[4];
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_ph_r  <= c1_ph;
    s1_inv_r <= in_data.inv_bus;
    s1_nr_r  <= (in_data.inv_bus == '0) || (period_r == '0);

    s2_ph_r  <= s1_ph_r;
    s2_hi_r  <= c2_hi;
    s2_lo_r  <= c2_lo;
    s2_inv_r <= s1_inv_r;
    s2_nr_r  <= s1_nr_r;

    s3_d_r   <= c3_d;
    s3_inv_r <= s2_inv_r;
    s3_nr_r  <= s2_nr_r;

    s4_pph_r <= c4_pph;
    s4_ppl_r <= c4_ppl;
    s4_nr_r  <= s3_nr_r;

    s5_duty_r <= c5_duty;
    s5_nr_r   <= s4_nr_r;

    // not ready forces all ticks to zero
    if (s5_nr_r) begin
      out_data_r.ticks_a <= '0;
      out_data_r.ticks_b <= '0;
      out_data_r.ticks_c <= '0;
      out_data_r.status  <= 1'b1;
    end else begin
      out_data_r.ticks_a <= c6_ticks[0];
      out_data_r.ticks_b <= c6_ticks[1];
      out_data_r.ticks_c <= c6_ticks[2];
      out_data_r.status  <= 1'b0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // every taken beat gives one result on out_strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_strobe)
    else $error("result missing six cycles after accepted beat");

  // no result without an earlier taken beat
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 6))
    else $error("result without an accepted beat");

  // zero reciprocal travels to a not-ready status
  a_nr_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_data.inv_bus == '0, 6)) |-> out_data.status)
    else $error("zero inv_bus did not give not ready");

  // not ready carries zero ticks on all phases
  a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status) |->
      (out_data.ticks_a == '0 && out_data.ticks_b == '0 && out_data.ticks_c == '0))
    else $error("not ready result with nonzero ticks");

endmodule
